// ----- rtl/voltmeter_minmax_display_top_defines.svh -----
// assertion macros for the voltmeter min/max display block
// expects clk_i and rst_ni in the scope of use
`ifndef VOLTMETER_MINMAX_DISPLAY_TOP_DEFINES_SVH
`define VOLTMETER_MINMAX_DISPLAY_TOP_DEFINES_SVH

// property holds at every edge out of reset
`define VMD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition never seen out of reset
`define VMD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/vmd_pkg.sv -----
// shared types, constants and helper functions of the voltmeter display block
// no dependencies
package vmd_pkg;

  localparam int unsigned SAMPLES_PER_AVERAGE_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF         = 4;

  localparam int unsigned OP_W      = 2;
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned SEG_W     = 7;
  localparam int unsigned VOLT_W    = 6;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MSG_IDX_W = 4;

  localparam int unsigned VOLT_STEPS   = 33;
  localparam int unsigned ADC_FULL     = 1023;
  localparam int unsigned ADC_ROUND    = 511;
  localparam int unsigned DECIMAL_BASE = 10;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_RX     = 2'd2;

  localparam logic KIND_DISPLAY = 1'b0;
  localparam logic KIND_TX      = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_MAX  = 8'h4D;
  localparam logic [CHAR_W-1:0] CHAR_MIN  = 8'h6D;
  localparam logic [CHAR_W-1:0] CHAR_NL   = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;

  localparam logic [VOLT_W-1:0] VOLT_LOW_RESET = 6'd33;

  localparam int unsigned LABEL_LEN    = 8;
  localparam int unsigned MSG_TENS_POS = 8;
  localparam int unsigned MSG_ONES_POS = 9;
  localparam int unsigned MSG_LEN      = 11;

  localparam logic [8*LABEL_LEN-1:0] LABEL_MAX = "voltMax:";
  localparam logic [8*LABEL_LEN-1:0] LABEL_MIN = "voltMin:";

  typedef enum logic [1:0] {
    CLS_AVG,
    CLS_TICK,
    CLS_MAX,
    CLS_MIN
  } cls_e;

  typedef struct packed {
    logic               is_msg;
    logic               is_max;
    logic [SEG_W-1:0]   segments;
    logic               digit_select;
    logic [DIGIT_W-1:0] tens;
    logic [DIGIT_W-1:0] ones;
  } job_t;

  typedef struct packed {
    logic              kind;
    logic [SEG_W-1:0]  segments;
    logic              digit_select;
    logic [CHAR_W-1:0] tx_byte;
    logic              last;
  } res_t;

  function automatic logic [DIGIT_W-1:0] tens_of(logic [VOLT_W-1:0] v);
    logic [DIGIT_W-1:0] t;
    t = '0;
    if (v >= VOLT_W'(60))      t = DIGIT_W'(6);
    else if (v >= VOLT_W'(50)) t = DIGIT_W'(5);
    else if (v >= VOLT_W'(40)) t = DIGIT_W'(4);
    else if (v >= VOLT_W'(30)) t = DIGIT_W'(3);
    else if (v >= VOLT_W'(20)) t = DIGIT_W'(2);
    else if (v >= VOLT_W'(10)) t = DIGIT_W'(1);
    return t;
  endfunction

  function automatic logic [DIGIT_W-1:0] ones_of(logic [VOLT_W-1:0] v);
    logic [VOLT_W-1:0] rem;
    rem = v - VOLT_W'(VOLT_W'(tens_of(v)) * VOLT_W'(DECIMAL_BASE));
    return rem[DIGIT_W-1:0];
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [CHAR_W-1:0] msg_byte(job_t j, logic [MSG_IDX_W-1:0] idx);
    logic [8*LABEL_LEN-1:0] lbl;
    logic [CHAR_W-1:0]      b;
    int unsigned            pos;
    lbl = j.is_max ? LABEL_MAX : LABEL_MIN;
    pos = int'(idx[2:0]);
    if (idx < MSG_IDX_W'(LABEL_LEN))          b = lbl[8*(LABEL_LEN-1-pos) +: 8];
    else if (idx == MSG_IDX_W'(MSG_TENS_POS)) b = CHAR_ZERO + CHAR_W'(j.tens);
    else if (idx == MSG_IDX_W'(MSG_ONES_POS)) b = CHAR_ZERO + CHAR_W'(j.ones);
    else                                      b = CHAR_NL;
    return b;
  endfunction

endpackage

// ----- rtl/vmd_if.sv -----
// valid/ready channel interfaces for requests in and results out
// depends on vmd_pkg
interface vmd_in_if import vmd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [SAMPLE_W-1:0] sample;
  logic [CHAR_W-1:0]   rx_char;

  modport source (output valid, op, sample, rx_char, input ready);
  modport sink   (input valid, op, sample, rx_char, output ready);
endinterface

interface vmd_out_if import vmd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SEG_W-1:0]  segments;
  logic              digit_select;
  logic [CHAR_W-1:0] tx_byte;
  logic              last;

  modport source (output valid, kind, segments, digit_select, tx_byte, last, input ready);
  modport sink   (input valid, kind, segments, digit_select, tx_byte, last, output ready);
endinterface

// ----- rtl/vmd_fifo.sv -----
// small job queue between front and back end, flop storage
// depends on vmd_pkg
module vmd_fifo import vmd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/vmd_front.sv -----
// front end: accepts requests, averages samples, tracks min/max, builds jobs
// depends on vmd_pkg and vmd_if
module vmd_front import vmd_pkg::*; #(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  vmd_in_if.sink   in_i,
  output job_t     job_o,
  output logic     push_o,
  input  logic     full_i
);

  localparam int unsigned SUM_W = $clog2(SAMPLES_PER_AVERAGE * ADC_FULL + 1);
  localparam int unsigned CNT_W = $clog2(SAMPLES_PER_AVERAGE);

  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [SUM_W-1:0]      sum_next;
  logic                  wrap;
  logic [VOLT_STEPS-1:0] thermo;

  logic                  advance;
  logic                  accept;
  logic                  cls_valid;
  cls_e                  cls;

  logic                  s1_valid_q;
  cls_e                  s1_cls_q;
  logic [VOLT_STEPS-1:0] s1_thermo_q;
  logic [VOLT_STEPS:0]   thermo_ext;
  logic [VOLT_W-1:0]     volt_enc;

  logic                  s2_valid_q;
  cls_e                  s2_cls_q;
  logic [VOLT_W-1:0]     s2_volt_q;

  logic [VOLT_W-1:0]     volt_now_q, volt_now_d;
  logic [VOLT_W-1:0]     volt_low_q, volt_low_d;
  logic [VOLT_W-1:0]     volt_high_q, volt_high_d;
  logic                  show_high_q, show_high_d;
  logic [DIGIT_W-1:0]    digit;
  logic [VOLT_W-1:0]     msg_volt;

  assign advance    = !(s2_valid_q && (s2_cls_q != CLS_AVG) && full_i);
  assign in_i.ready = advance;
  assign accept     = in_i.valid && advance;
  assign push_o     = s2_valid_q && (s2_cls_q != CLS_AVG) && advance;

  // sample accumulation
  assign sum_next = sum_q + SUM_W'(in_i.sample);
  assign wrap     = (cnt_q == CNT_W'(SAMPLES_PER_AVERAGE - 1));

  // volt >= k exactly when the sum reaches the scaled rounding threshold
  for (genvar k = 1; k <= VOLT_STEPS; k++) begin : g_thr
    localparam int unsigned THR =
      SAMPLES_PER_AVERAGE * ((ADC_FULL * k - ADC_ROUND + VOLT_STEPS - 1) / VOLT_STEPS);
    assign thermo[k-1] = (sum_next >= SUM_W'(THR));
  end

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept && (in_i.op == OP_SAMPLE)) begin
      sum_d = wrap ? '0 : sum_next;
      cnt_d = wrap ? '0 : cnt_q + 1'b1;
    end
  end

  // request decode
  always_comb begin
    cls_valid = 1'b0;
    cls       = CLS_TICK;
    unique case (in_i.op)
      OP_SAMPLE: begin
        cls_valid = wrap;
        cls       = CLS_AVG;
      end
      OP_TICK: begin
        cls_valid = 1'b1;
        cls       = CLS_TICK;
      end
      OP_RX: begin
        if (in_i.rx_char == CHAR_MAX) begin
          cls_valid = 1'b1;
          cls       = CLS_MAX;
        end else if (in_i.rx_char == CHAR_MIN) begin
          cls_valid = 1'b1;
          cls       = CLS_MIN;
        end
      end
      default: begin
        cls_valid = 1'b0;
      end
    endcase
  end

  // thermometer to binary
  assign thermo_ext = {1'b0, s1_thermo_q};

  always_comb begin
    volt_enc = '0;
    for (int k = 0; k < VOLT_STEPS; k++) begin
      if (thermo_ext[k] && !thermo_ext[k+1]) begin
        volt_enc = volt_enc | VOLT_W'(k + 1);
      end
    end
  end

  // state update at the last stage
  always_comb begin
    volt_now_d  = volt_now_q;
    volt_low_d  = volt_low_q;
    volt_high_d = volt_high_q;
    show_high_d = show_high_q;
    if (s2_valid_q && advance) begin
      case (s2_cls_q)
        CLS_AVG: begin
          volt_now_d = s2_volt_q;
          if (s2_volt_q > volt_high_q) volt_high_d = s2_volt_q;
          if (s2_volt_q < volt_low_q)  volt_low_d  = s2_volt_q;
        end
        CLS_TICK: begin
          show_high_d = !show_high_q;
        end
        default: begin
          show_high_d = show_high_q;
        end
      endcase
    end
  end

  // job build
  assign digit    = show_high_q ? tens_of(volt_now_q) : ones_of(volt_now_q);
  assign msg_volt = (s2_cls_q == CLS_MAX) ? volt_high_q : volt_low_q;

  always_comb begin
    job_o = '0;
    if (s2_cls_q == CLS_TICK) begin
      job_o.segments     = seg_of(digit);
      job_o.digit_select = show_high_q;
    end else begin
      job_o.is_msg = 1'b1;
      job_o.is_max = (s2_cls_q == CLS_MAX);
      job_o.tens   = tens_of(msg_volt);
      job_o.ones   = ones_of(msg_volt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      cnt_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      volt_now_q  <= '0;
      volt_low_q  <= VOLT_LOW_RESET;
      volt_high_q <= '0;
      show_high_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      volt_now_q  <= volt_now_d;
      volt_low_q  <= volt_low_d;
      volt_high_q <= volt_high_d;
      show_high_q <= show_high_d;
      if (advance) begin
        s1_valid_q <= accept && cls_valid;
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_cls_q    <= cls;
      s1_thermo_q <= thermo;
      s2_cls_q    <= s1_cls_q;
      s2_volt_q   <= volt_enc;
    end
  end

endmodule

// ----- rtl/vmd_back.sv -----
// back end: expands jobs into display drives and serial bytes, output register
// depends on vmd_pkg and vmd_if
module vmd_back import vmd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      empty_i,
  output logic      pop_o,
  vmd_out_if.source out_o
);

  logic [MSG_IDX_W-1:0] idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  res_t                 res_q, res_d;
  logic                 load;
  logic                 final_res;

  assign load      = !empty_i && (!out_valid_q || out_o.ready);
  assign final_res = !job_i.is_msg || (idx_q == MSG_IDX_W'(MSG_LEN - 1));
  assign pop_o     = load && final_res;

  always_comb begin
    res_d = '0;
    if (job_i.is_msg) begin
      res_d.kind    = KIND_TX;
      res_d.tx_byte = msg_byte(job_i, idx_q);
      res_d.last    = final_res;
    end else begin
      res_d.kind         = KIND_DISPLAY;
      res_d.segments     = job_i.segments;
      res_d.digit_select = job_i.digit_select;
      res_d.last         = 1'b1;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      idx_d       = final_res ? '0 : idx_q + 1'b1;
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = res_q.kind;
  assign out_o.segments     = res_q.segments;
  assign out_o.digit_select = res_q.digit_select;
  assign out_o.tx_byte      = res_q.tx_byte;
  assign out_o.last         = res_q.last;

endmodule

// ----- rtl/voltmeter_minmax_display_top.sv -----
// Voltmeter with min/max tracking, a two-digit seven-segment drive and a serial
// report. A request is taken every cycle unless the job queue is full: samples
// are averaged in a two-stage front pipeline, display ticks give one result and
// an 'M' or 'm' character gives eleven message bytes. The back end sends one
// result per cycle from its output register while the output is ready; QUEUE_DEPTH
// + 1 jobs can wait behind a message (QUEUE_DEPTH - 1 in the queue, two in the
// front pipeline) before the input stalls. A request passes the two front stages,
// the job queue and the output register before its result appears.
// Depends on vmd_pkg, vmd_if, vmd_fifo, vmd_front and vmd_back.
`include "voltmeter_minmax_display_top_defines.svh"

module voltmeter_minmax_display_top import vmd_pkg::*; #(
  parameter int unsigned SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF,
  parameter int unsigned QUEUE_DEPTH         = QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vmd_in_if.sink    in_i,
  vmd_out_if.source out_o
);

  job_t q_wr_data;
  job_t q_rd_data;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  vmd_front #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .job_o  (q_wr_data),
    .push_o (q_push),
    .full_i (q_full)
  );

  vmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_data),
    .pop_i   (q_pop),
    .data_o  (q_rd_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  vmd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (q_rd_data),
    .empty_i (q_empty),
    .pop_o   (q_pop),
    .out_o   (out_o)
  );

  `VMD_ASSERT_NEVER(a_no_push_full, q_push && q_full, "job queue written while full")
  `VMD_ASSERT_NEVER(a_no_pop_empty, q_pop && q_empty, "job queue read while empty")
  `VMD_ASSERT(a_stall_cause, !in_i.ready |-> q_full, "input stalled without a full queue")
  `VMD_ASSERT(a_display_single, out_o.valid && out_o.kind == KIND_DISPLAY |-> out_o.last && out_o.tx_byte == '0, "display result not single or has a byte")

endmodule
